// File: src/dpf_pkg.sv
// Shared types, codes and helpers for the debug packet framer.
`timescale 1ns / 1ps
package dpf_pkg;

	localparam logic [2:0] OP_START  = 3'd0;
	localparam logic [2:0] OP_RAW    = 3'd1;
	localparam logic [2:0] OP_BYTE   = 3'd2;
	localparam logic [2:0] OP_NIBBLE = 3'd3;
	localparam logic [2:0] OP_FINISH = 3'd4;

	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_END   = 8'h23;

	localparam logic [15:0] LIMIT_RESET = 16'd1023;

	// One queued job: up to three link characters produced by one input word.
	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] ch0;
		logic [7:0] ch1;
		logic [7:0] ch2;
		logic       fin;
	} entry_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = 8'h30 + {4'd0, n};
		end else begin
			r = 8'h57 + {4'd0, n};
		end
		return r;
	endfunction

endpackage

// File: src/dpf_channels.sv
// Handshake channel interfaces for the input, result and register write words.
`timescale 1ns / 1ps
interface dpf_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [7:0] data;
	modport source (output valid, output op, output data, input ready);
	modport sink (input valid, input op, input data, output ready);
endinterface

interface dpf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       run_last;
	logic       frame_end;
	modport source (output valid, output out_char, output run_last, output frame_end,
		input ready);
	modport sink (input valid, input out_char, input run_last, input frame_end,
		output ready);
endinterface

interface dpf_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/dpf_front.sv
// Front end: accepts words, applies the payload limit and checksum, builds jobs.
`timescale 1ns / 1ps
module dpf_front (
	input  logic            clk,
	input  logic            arst_n,
	dpf_in_if.sink          in_ch,
	dpf_cfg_if.sink         cfg,
	input  logic            q_full,
	output logic            push,
	output dpf_pkg::entry_t push_ent
);
	import dpf_pkg::*;

	logic [15:0] limit_q;
	logic [15:0] count_q;
	logic [7:0]  sum_q;
	logic [15:0] count_d;
	logic [7:0]  sum_d;
	logic [7:0]  hi_ch;
	logic [7:0]  lo_ch;
	logic        room0;
	logic        room1;
	logic        fire;
	entry_t      ent;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = !q_full;
	assign fire        = in_ch.valid && in_ch.ready;
	assign push        = fire && (ent.cnt != 2'd0);
	assign push_ent    = ent;

	always_comb begin
		hi_ch = hex_digit(in_ch.data[7:4]);
		lo_ch = hex_digit(in_ch.data[3:0]);
		room0 = count_q < limit_q;
		// Room for a second character of a byte item.
		room1 = ({1'b0, count_q} + 17'd1) < {1'b0, limit_q};
		ent     = '0;
		count_d = count_q;
		sum_d   = sum_q;
		unique case (in_ch.op)
			OP_START: begin
				ent.cnt = 2'd1;
				ent.ch0 = CH_START;
				count_d = '0;
				sum_d   = '0;
			end
			OP_RAW: begin
				if (room0) begin
					ent.cnt = 2'd1;
					ent.ch0 = in_ch.data;
					count_d = count_q + 16'd1;
					sum_d   = sum_q + in_ch.data;
				end
			end
			OP_BYTE: begin
				if (room0) begin
					ent.ch0 = hi_ch;
					ent.ch1 = lo_ch;
					if (room1) begin
						ent.cnt = 2'd2;
						count_d = count_q + 16'd2;
						sum_d   = sum_q + hi_ch + lo_ch;
					end else begin
						ent.cnt = 2'd1;
						count_d = count_q + 16'd1;
						sum_d   = sum_q + hi_ch;
					end
				end
			end
			OP_NIBBLE: begin
				if (room0) begin
					ent.cnt = 2'd1;
					ent.ch0 = lo_ch;
					count_d = count_q + 16'd1;
					sum_d   = sum_q + lo_ch;
				end
			end
			OP_FINISH: begin
				ent.cnt = 2'd3;
				ent.ch0 = CH_END;
				ent.ch1 = hex_digit(sum_q[7:4]);
				ent.ch2 = hex_digit(sum_q[3:0]);
				ent.fin = 1'b1;
			end
			default: begin
				ent = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			count_q <= '0;
			sum_q   <= '0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.data;
			end
			if (fire) begin
				count_q <= count_d;
				sum_q   <= sum_d;
			end
		end
	end

endmodule

// File: src/dpf_queue.sv
// Small job queue between the front end and the character serializer.
`timescale 1ns / 1ps
module dpf_queue #(
	parameter int Depth = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dpf_pkg::entry_t push_ent,
	input  logic            pop,
	output dpf_pkg::entry_t head,
	output logic            full,
	output logic            empty
);
	import dpf_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

	entry_t          mem_q [Depth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;

	assign full  = cnt_q == CntW'(Depth);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/dpf_back.sv
// Back end: sends the characters of each queued job one word at a time.
`timescale 1ns / 1ps
module dpf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  dpf_pkg::entry_t head,
	input  logic            empty,
	output logic            pop,
	dpf_out_if.source       out_ch
);
	import dpf_pkg::*;

	entry_t     cur_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       last;
	logic       take;

	assign last  = idx_q == (cur_q.cnt - 2'd1);
	assign take  = out_ch.valid && out_ch.ready;
	// Load the next job as the current one finishes, so jobs run without gaps.
	assign pop   = (!busy_q || (take && last)) && !empty;

	assign out_ch.valid     = busy_q;
	assign out_ch.run_last  = last;
	assign out_ch.frame_end = last && cur_q.fin;

	always_comb begin
		case (idx_q)
			2'd0:    out_ch.out_char = cur_q.ch0;
			2'd1:    out_ch.out_char = cur_q.ch1;
			default: out_ch.out_char = cur_q.ch2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (take && last) begin
				busy_q <= 1'b0;
			end else if (take) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// File: src/debug_packet_framer_core.sv
// Top level of the debug packet framer.
//
// Usage: in_ch takes one word per op (start, raw character, byte as hex,
// nibble as hex, finish). out_ch sends the framed packet one character per
// word; run_last marks the last character of an input word and frame_end
// marks the second checksum digit. cfg writes payload_limit at any time the
// block is idle; cfg.ready is always high.
// With the queue empty and the serializer idle, the first character of a
// word is offered once it has passed through the job queue and the
// serializer's current-job register. The link sends one character per
// cycle while the receiver takes them and jobs are queued, so a word yields
// one to three characters; words that yield nothing are not queued and send
// none. The serializer sets this rate.
// The front end accepts a word each cycle while the job queue has room,
// even while the receiver stalls; once the queue is full, in_ch.ready
// drops until the serializer frees an entry.
// Reset clears the queue, the payload count and checksum, and sets
// payload_limit to 1023.
`timescale 1ns / 1ps
module debug_packet_framer_core #(
	parameter int QueueDepth = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	dpf_in_if.sink    in_ch,
	dpf_out_if.source out_ch,
	dpf_cfg_if.sink   cfg
);
	import dpf_pkg::*;

	entry_t push_ent;
	entry_t head;
	logic   push;
	logic   pop;
	logic   q_full;
	logic   q_empty;

	dpf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.push_ent (push_ent)
	);

	dpf_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	dpf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (q_empty),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

// File: src/dpf_check.sv
// Port-level checks for the debug packet framer, bound to the top level.
`timescale 1ns / 1ps
module dpf_check (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       run_last,
	input logic       frame_end,
	input logic       cfg_ready
);

	// A stalled word must hold its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char)
			&& $stable(run_last) && $stable(frame_end))
		else $error("output word changed while stalled");

	// The closing checksum digit is always the last character of its word.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last)
		else $error("frame_end without run_last");

	// The closing checksum digit is a lowercase hex digit.
	a_end_hex: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |->
			(out_char >= 8'h30 && out_char <= 8'h39)
			|| (out_char >= 8'h61 && out_char <= 8'h66))
		else $error("frame_end on a non-hex character");

	// Register writes are never back-pressured.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("register write port not ready");

endmodule

bind debug_packet_framer_core dpf_check u_dpf_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_char  (out_ch.out_char),
	.run_last  (out_ch.run_last),
	.frame_end (out_ch.frame_end),
	.cfg_ready (cfg.ready)
);
